// File: src/hmcg_pkg.sv
// Shared types and constants of the heat map color gradient.
// No dependencies; every module of the block imports this package.
package hmcg_pkg;

   localparam int STOP_COUNT = 5;
   localparam int STOP_INDEX_WIDTH = 3;
   localparam int CHANNELS = 3;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RANGE_LOW = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RANGE_HIGH = 1'b1;

   localparam logic [31:0] RANGE_LOW_RESET = 32'd0;
   localparam logic [31:0] RANGE_HIGH_RESET = 32'd65535;

   localparam logic [STOP_INDEX_WIDTH-1:0] STOP_FIRST = 3'd0;
   localparam logic [STOP_INDEX_WIDTH-1:0] STOP_LAST = 3'd4;

   // Color stops, light cream to dark red, as (red, green, blue).
   localparam logic [7:0] STOP_TAB [STOP_COUNT][CHANNELS] = '{
      '{8'd254, 8'd240, 8'd217},
      '{8'd253, 8'd204, 8'd138},
      '{8'd252, 8'd141, 8'd89},
      '{8'd227, 8'd74, 8'd51},
      '{8'd179, 8'd0, 8'd0}
   };

   // How a sample resolves: interpolated, or pinned to an end stop.
   typedef enum logic [1:0] {
      CLS_INTERP,
      CLS_FIRST,
      CLS_LAST
   } cls_type;

endpackage

// File: src/hmcg_if.sv
// Valid/ready channel interfaces of the heat map color gradient.
// Depends on nothing; the top level uses them for its sample and color ports.
interface hmcg_req_if #(parameter int VALUE_WIDTH = 32);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink (input valid, input sample_value, output ready);
endinterface

interface hmcg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// File: src/hmcg_front.sv
// Front end: offset and span against the range bounds, then the end-stop class.
// Depends on hmcg_pkg. Two register stages with valid/ready flow control.
module hmcg_front #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [VALUE_WIDTH-1:0]  sample_value,
   input  logic [VALUE_WIDTH-1:0]  range_low,
   input  logic [VALUE_WIDTH-1:0]  range_high,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [VALUE_WIDTH:0]    out_a,
   output logic [VALUE_WIDTH:0]    out_b,
   output hmcg_pkg::cls_type       out_cls
);
   import hmcg_pkg::*;

   logic                   v1_ff;
   logic [VALUE_WIDTH:0]   num_ff, num_in;
   logic [VALUE_WIDTH:0]   den_ff, den_in;
   logic                   v2_ff;
   logic [VALUE_WIDTH:0]   a_ff, a_in;
   logic [VALUE_WIDTH:0]   b_ff, b_in;
   cls_type                cls_ff, cls_in;
   logic                   rdy1, rdy2;
   logic                   num_neg, den_neg, ge;

   assign rdy2 = !v2_ff || out_ready;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Sign-extend by one bit so neither difference can overflow.
   assign num_in = {sample_value[VALUE_WIDTH-1], sample_value}
                 - {range_low[VALUE_WIDTH-1], range_low};
   assign den_in = {range_high[VALUE_WIDTH-1], range_high}
                 - {range_low[VALUE_WIDTH-1], range_low};

   assign num_neg = num_ff[VALUE_WIDTH];
   assign den_neg = den_ff[VALUE_WIDTH];
   assign a_in = num_neg ? (~num_ff + 1'b1) : num_ff;
   assign b_in = den_neg ? (~den_ff + 1'b1) : den_ff;
   // |num| >= |den| for operands of the same sign, without the magnitudes.
   assign ge = den_neg ? ($signed(num_ff) <= $signed(den_ff))
                       : ($signed(num_ff) >= $signed(den_ff));

   always_comb begin
      priority if (den_ff == '0) begin
         cls_in = num_neg ? CLS_FIRST : CLS_LAST;
      end else if ((num_ff == '0) || (num_neg != den_neg)) begin
         cls_in = CLS_FIRST;
      end else if (ge) begin
         cls_in = CLS_LAST;
      end else begin
         cls_in = CLS_INTERP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
      if (rdy2 && v1_ff) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         cls_ff <= cls_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_a = a_ff;
   assign out_b = b_ff;
   assign out_cls = cls_ff;

endmodule

// File: src/hmcg_div_step.sv
// One restoring division step: yields one fraction bit per register stage.
// Depends on hmcg_pkg. Chained FRACTION_BITS times by the top level.
module hmcg_div_step #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [VALUE_WIDTH:0]      in_rem,
   input  logic [VALUE_WIDTH:0]      in_div,
   input  logic [FRACTION_BITS-1:0]  in_quot,
   input  hmcg_pkg::cls_type         in_cls,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [VALUE_WIDTH:0]      out_rem,
   output logic [VALUE_WIDTH:0]      out_div,
   output logic [FRACTION_BITS-1:0]  out_quot,
   output hmcg_pkg::cls_type         out_cls
);
   import hmcg_pkg::*;

   logic                      v_ff;
   logic [VALUE_WIDTH:0]      rem_ff, rem_in;
   logic [VALUE_WIDTH:0]      div_ff;
   logic [FRACTION_BITS-1:0]  quot_ff, quot_in;
   cls_type                   cls_ff;
   logic                      rdy;
   logic [VALUE_WIDTH+1:0]    shifted, trial;
   logic                      take;

   assign rdy = !v_ff || out_ready;
   assign in_ready = rdy;

   assign shifted = {in_rem, 1'b0};
   assign trial = shifted - {1'b0, in_div};
   assign take = shifted >= {1'b0, in_div};
   assign rem_in = take ? trial[VALUE_WIDTH:0] : shifted[VALUE_WIDTH:0];
   assign quot_in = {in_quot[FRACTION_BITS-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (rdy) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy && in_valid) begin
         rem_ff  <= rem_in;
         div_ff  <= in_div;
         quot_ff <= quot_in;
         cls_ff  <= in_cls;
      end
   end

   assign out_valid = v_ff;
   assign out_rem = rem_ff;
   assign out_div = div_ff;
   assign out_quot = quot_ff;
   assign out_cls = cls_ff;

endmodule

// File: src/hmcg_interp.sv
// Segment pick and linear blend between neighboring color stops.
// Depends on hmcg_pkg. Multiply stage, then add/select stage feeding the output.
module hmcg_interp #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [FRACTION_BITS-1:0]  in_quot,
   input  hmcg_pkg::cls_type         in_cls,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [7:0]                out_red,
   output logic [7:0]                out_green,
   output logic [7:0]                out_blue
);
   import hmcg_pkg::*;

   localparam int PROD_WIDTH = FRACTION_BITS + 10;

   logic                          va_ff, vb_ff;
   logic                          rdy_a, rdy_b;
   logic [1:0]                    seg;
   logic [FRACTION_BITS-1:0]      frac;
   logic [STOP_INDEX_WIDTH-1:0]   idx_lo, idx_hi;
   logic signed [8:0]             diff [CHANNELS];
   logic signed [PROD_WIDTH-1:0]  prod_in [CHANNELS];
   logic signed [PROD_WIDTH-1:0]  prod_ff [CHANNELS];
   logic [7:0]                    base_ff [CHANNELS];
   cls_type                       cls_ff;
   logic [7:0]                    color_in [CHANNELS];
   logic [7:0]                    color_ff [CHANNELS];

   assign rdy_b = !vb_ff || out_ready;
   assign rdy_a = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   // Four times the fraction: top two bits pick the segment, the rest blends.
   assign seg = in_quot[FRACTION_BITS-1 -: 2];
   assign frac = {in_quot[FRACTION_BITS-3:0], 2'b00};
   assign idx_lo = {1'b0, seg};
   assign idx_hi = idx_lo + 1'b1;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         diff[c] = $signed({1'b0, STOP_TAB[idx_hi][c]}) - $signed({1'b0, STOP_TAB[idx_lo][c]});
         prod_in[c] = PROD_WIDTH'(diff[c] * $signed({1'b0, frac}));
      end
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         unique case (cls_ff)
            CLS_FIRST: color_in[c] = STOP_TAB[STOP_FIRST][c];
            CLS_LAST:  color_in[c] = STOP_TAB[STOP_LAST][c];
            default:   color_in[c] = base_ff[c] + 8'(prod_ff[c] >>> FRACTION_BITS);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            va_ff <= in_valid;
         end
         if (rdy_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         cls_ff <= in_cls;
         for (int c = 0; c < CHANNELS; c++) begin
            prod_ff[c] <= prod_in[c];
            base_ff[c] <= STOP_TAB[idx_lo][c];
         end
      end
      if (rdy_b && va_ff) begin
         for (int c = 0; c < CHANNELS; c++) begin
            color_ff[c] <= color_in[c];
         end
      end
   end

   assign out_valid = vb_ff;
   assign out_red = color_ff[0];
   assign out_green = color_ff[1];
   assign out_blue = color_ff[2];

endmodule

// File: src/heat_map_color_gradient.sv
// Heat map color gradient: maps each signed sample to an RGB color on a five-stop
// scale from light cream to dark red, by (sample - range_low) / (range_high - range_low)
// as an unsigned FRACTION_BITS-bit fraction. One transaction is accepted every clock
// while the output is not stalled, and each gives exactly one color transaction: two
// front stages form the offset, span and end-stop class, one stage per fraction bit
// runs the restoring divider, and two stages do the multiply and the add. Every stage
// holds its own valid bit and stalls only while full and blocked downstream, so a
// stalled rsp channel backs up one stage at a time and nothing is dropped or repeated.
// Write range_low (index 0) and range_high (index 1) through the csr port only while
// no transaction is in flight; reset values are 0 and 65535.
// Depends on hmcg_pkg, hmcg_if, hmcg_front, hmcg_div_step and hmcg_interp.
module heat_map_color_gradient #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   hmcg_req_if.sink                              req,
   hmcg_rsp_if.source                            rsp,
   input  logic                                  csr_we,
   input  logic [hmcg_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [VALUE_WIDTH-1:0]                csr_wdata
);
   import hmcg_pkg::*;

   localparam int LATENCY = FRACTION_BITS + 4;

   // Range bounds, held as two's complement at VALUE_WIDTH bits.
   logic [VALUE_WIDTH-1:0] range_low_ff;
   logic [VALUE_WIDTH-1:0] range_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= VALUE_WIDTH'(RANGE_LOW_RESET);
         range_high_ff <= VALUE_WIDTH'(RANGE_HIGH_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RANGE_LOW:  range_low_ff  <= csr_wdata;
            REG_RANGE_HIGH: range_high_ff <= csr_wdata;
            default:        range_low_ff  <= range_low_ff;
         endcase
      end
   end

   // Divider chain taps; tap 0 is the front-end output.
   logic                      div_valid [FRACTION_BITS+1];
   logic                      div_ready [FRACTION_BITS+1];
   logic [VALUE_WIDTH:0]      div_rem   [FRACTION_BITS+1];
   logic [VALUE_WIDTH:0]      div_div   [FRACTION_BITS+1];
   logic [FRACTION_BITS-1:0]  div_quot  [FRACTION_BITS+1];
   cls_type                   div_cls   [FRACTION_BITS+1];

   hmcg_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req.valid),
      .in_ready     (req.ready),
      .sample_value (req.sample_value),
      .range_low    (range_low_ff),
      .range_high   (range_high_ff),
      .out_valid    (div_valid[0]),
      .out_ready    (div_ready[0]),
      .out_a        (div_rem[0]),
      .out_b        (div_div[0]),
      .out_cls      (div_cls[0])
   );

   // Start the quotient at zero; the remainder starts as the offset magnitude.
   assign div_quot[0] = '0;

   for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_div
      hmcg_div_step #(
         .VALUE_WIDTH   (VALUE_WIDTH),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_ready  (div_ready[i]),
         .in_rem    (div_rem[i]),
         .in_div    (div_div[i]),
         .in_quot   (div_quot[i]),
         .in_cls    (div_cls[i]),
         .out_valid (div_valid[i+1]),
         .out_ready (div_ready[i+1]),
         .out_rem   (div_rem[i+1]),
         .out_div   (div_div[i+1]),
         .out_quot  (div_quot[i+1]),
         .out_cls   (div_cls[i+1])
      );
   end

   // A zero quotient lands on segment 0 with no blend, which is the first stop.
   hmcg_interp #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[FRACTION_BITS]),
      .in_ready  (div_ready[FRACTION_BITS]),
      .in_quot   (div_quot[FRACTION_BITS]),
      .in_cls    (div_cls[FRACTION_BITS]),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_red   (rsp.red),
      .out_green (rsp.green),
      .out_blue  (rsp.blue)
   );

`ifndef SYNTHESIS
   // Count transactions in flight between the two channels.
   logic [$clog2(LATENCY+2)-1:0] inflight_ff, inflight_in;

   assign inflight_in = inflight_ff
                      + (($clog2(LATENCY+2))'(req.valid && req.ready))
                      - (($clog2(LATENCY+2))'(rsp.valid && rsp.ready));

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= ($clog2(LATENCY+2))'(LATENCY))
      else $error("more transactions in flight than pipeline stages");

   a_no_phantom_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (inflight_ff != '0))
      else $error("result presented with no transaction in flight");

   a_flow_through: assert property (@(posedge clock) disable iff (reset)
      (!rsp.valid || rsp.ready) |-> req.ready)
      else $error("input stalled while the output drains");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid right after reset");
`endif

endmodule
